// ===== sv/qs_pkg.sv =====
// Shared types, constants and per-stage datapath for the quaternion slerp pipeline.
// No dependencies; used by every other file except qs_if through scoped names.
package qs_pkg;

    localparam int COMP_FRAC_BITS = 14;
    localparam int CORDIC_STEPS   = 16;

    localparam logic signed [33:0] ANG_PI          = 34'sd3373259426;
    localparam logic signed [33:0] ANG_HALF_PI     = 34'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

    localparam logic [2:0] ADDR_THR   = 3'd0;
    localparam logic [14:0] THR_RESET = 15'd16;

    typedef enum logic [1:0] {
        PATH_INTERP = 2'd0,
        PATH_A      = 2'd1,
        PATH_MID    = 2'd2
    } t_path;

    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [16:0]      t;
        t_path            path;
        logic             cneg;
        logic [3:0][31:0] dp;
        logic [29:0]      cq;
        logic [61:0]      rem;
        logic [61:0]      root;
        logic [30:0]      s;
        logic [33:0]      cx;
        logic [33:0]      cy;
        logic [33:0]      cz;
        logic [31:0]      theta;
        logic [33:0]      ax;
        logic [33:0]      ay;
        logic [33:0]      az;
        logic [33:0]      bx;
        logic [33:0]      by;
        logic [33:0]      bz;
        logic [3:0][49:0] pa;
        logic [3:0][49:0] pb;
        logic [3:0][50:0] num;
        logic [3:0]       nneg;
        logic [3:0][47:0] drem;
        logic [3:0]       ovf;
        logic [3:0][16:0] q;
        logic [3:0][15:0] r;
    } t_item;

    // pipeline depth for a given CORDIC length
    function automatic int qs_stages(input int n);
        return 60 + 2 * n;
    endfunction

    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] v;
        case (i)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            24: v = 30'd64;
            25: v = 30'd32;
            26: v = 30'd16;
            27: v = 30'd8;
            28: v = 30'd4;
            29: v = 30'd2;
            30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Work done by stage k of the pipeline; k is constant per instance.
    function automatic t_item qs_step(input int k, input int n, input t_item d,
                                      input logic [14:0] thr);
        t_item              o;
        int                 v;
        int                 p;
        int                 i;
        int                 j;
        logic signed [33:0] sum;
        logic [33:0]        cmag;
        logic [59:0]        csq;
        logic [61:0]        bitv;
        logic [61:0]        trial;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] th;
        logic [48:0]        pma;
        logic [48:0]        pmb;
        logic [50:0]        mag;
        logic [47:0]        sub;
        logic [16:0]        sm;
        logic [16:0]        nq;
        o = d;
        v = 35 + n;
        p = 38 + 2 * n;
        if (k == 0) begin
            for (i = 0; i < 4; i++) begin
                o.dp[i] = 32'($signed(d.a[i]) * $signed(d.b[i]));
            end
            if (d.t > 17'd65536) o.t = 17'd65536;
        end else if (k == 1) begin
            sum = 34'($signed(d.dp[0])) + 34'($signed(d.dp[1]))
                + 34'($signed(d.dp[2])) + 34'($signed(d.dp[3]));
            o.cneg = sum[33];
            cmag   = sum[33] ? 34'(-sum) : sum;
            o.path = (cmag >= (34'd1 << (2 * COMP_FRAC_BITS))) ? PATH_A : PATH_INTERP;
            o.cq   = 30'(cmag << (30 - 2 * COMP_FRAC_BITS));
        end else if (k == 2) begin
            csq    = 60'(d.cq) * 60'(d.cq);
            o.rem  = (62'd1 << 60) - {2'b00, csq};
            o.root = '0;
        end else if (k < 34) begin
            bitv  = 62'd1 << (60 - 2 * (k - 3));
            trial = d.root + bitv;
            if (d.rem >= trial) begin
                o.rem  = d.rem - trial;
                o.root = (d.root >> 1) + bitv;
            end else begin
                o.root = d.root >> 1;
            end
        end else if (k == 34) begin
            o.s = d.root[30:0];
            if (d.path == PATH_INTERP &&
                d.root[30:0] < (31'(thr) << (30 - COMP_FRAC_BITS))) begin
                o.path = PATH_MID;
            end
            o.cx = {4'b0000, d.cq};
            o.cy = {3'b000, d.root[30:0]};
            o.cz = '0;
        end else if (k < v) begin
            i  = k - 35;
            dx = $signed(d.cy) >>> i;
            dy = $signed(d.cx) >>> i;
            if (!d.cy[33]) begin
                o.cx = $signed(d.cx) + dx;
                o.cy = $signed(d.cy) - dy;
                o.cz = $signed(d.cz) + $signed({4'b0000, atan_q30(i)});
            end else begin
                o.cx = $signed(d.cx) - dx;
                o.cy = $signed(d.cy) + dy;
                o.cz = $signed(d.cz) - $signed({4'b0000, atan_q30(i)});
            end
        end else if (k == v) begin
            th = d.cneg ? ANG_PI - $signed(d.cz) : $signed(d.cz);
            if (th[33]) th = '0;
            o.theta = th[31:0];
        end else if (k == v + 1) begin
            pma  = 49'(d.theta) * 49'(17'd65536 - d.t);
            pmb  = 49'(d.theta) * 49'(d.t);
            o.az = {1'b0, pma[48:16]};
            o.bz = {1'b0, pmb[48:16]};
        end else if (k == v + 2) begin
            if ($signed(d.az) > ANG_HALF_PI) o.az = ANG_PI - $signed(d.az);
            if ($signed(d.bz) > ANG_HALF_PI) o.bz = ANG_PI - $signed(d.bz);
            o.ax = CORDIC_GAIN_INV;
            o.ay = '0;
            o.bx = CORDIC_GAIN_INV;
            o.by = '0;
        end else if (k < p) begin
            i  = k - (v + 3);
            dx = $signed(d.ay) >>> i;
            dy = $signed(d.ax) >>> i;
            if (!d.az[33]) begin
                o.ax = $signed(d.ax) - dx;
                o.ay = $signed(d.ay) + dy;
                o.az = $signed(d.az) - $signed({4'b0000, atan_q30(i)});
            end else begin
                o.ax = $signed(d.ax) + dx;
                o.ay = $signed(d.ay) - dy;
                o.az = $signed(d.az) + $signed({4'b0000, atan_q30(i)});
            end
            dx = $signed(d.by) >>> i;
            dy = $signed(d.bx) >>> i;
            if (!d.bz[33]) begin
                o.bx = $signed(d.bx) - dx;
                o.by = $signed(d.by) + dy;
                o.bz = $signed(d.bz) - $signed({4'b0000, atan_q30(i)});
            end else begin
                o.bx = $signed(d.bx) + dx;
                o.by = $signed(d.by) - dy;
                o.bz = $signed(d.bz) + $signed({4'b0000, atan_q30(i)});
            end
        end else if (k == p) begin
            for (i = 0; i < 4; i++) begin
                o.pa[i] = 50'($signed(d.a[i]) * $signed(d.ay));
                o.pb[i] = 50'($signed(d.b[i]) * $signed(d.by));
            end
        end else if (k == p + 1) begin
            for (i = 0; i < 4; i++) begin
                o.num[i]  = 51'($signed(d.pa[i])) + 51'($signed(d.pb[i]));
                o.nneg[i] = o.num[i][50];
            end
        end else if (k == p + 2) begin
            for (i = 0; i < 4; i++) begin
                mag       = d.nneg[i] ? 51'(-$signed(d.num[i])) : d.num[i];
                o.drem[i] = 48'(mag) + 48'(d.s >> 1);
            end
        end else if (k == p + 3) begin
            for (i = 0; i < 4; i++) begin
                o.ovf[i] = d.drem[i] >= ({17'b0, d.s} << 17);
                o.q[i]   = '0;
            end
        end else if (k < p + 21) begin
            j   = 16 - (k - (p + 4));
            sub = {17'b0, d.s} << j;
            for (i = 0; i < 4; i++) begin
                if (d.drem[i] >= sub) begin
                    o.drem[i]    = d.drem[i] - sub;
                    o.q[i][j]    = 1'b1;
                end
            end
        end else begin
            for (i = 0; i < 4; i++) begin
                sm = {d.a[i][15], d.a[i]} + {d.b[i][15], d.b[i]};
                nq = 17'd0 - d.q[i];
                case (d.path)
                    PATH_A:   o.r[i] = d.a[i];
                    PATH_MID: o.r[i] = sm[16:1];
                    default: begin
                        if (d.nneg[i]) begin
                            o.r[i] = (d.ovf[i] || d.q[i] > 17'd32768) ? 16'h8000 : nq[15:0];
                        end else begin
                            o.r[i] = (d.ovf[i] || d.q[i] > 17'd32767) ? 16'h7fff : d.q[i][15:0];
                        end
                    end
                endcase
            end
        end
        return o;
    endfunction

endpackage

// ===== sv/qs_if.sv =====
// Item channels of the quaternion slerp block: input pair and result.
// Depends on nothing.
interface qs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] a_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] b_w;
    logic [16:0]        blend;

    modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                    input ready);
    modport sink   (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
                    output ready);
endinterface

interface qs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic signed [15:0] r_w;
    logic [1:0]         path_taken;

    modport source (output valid, r_x, r_y, r_z, r_w, path_taken, input ready);
    modport sink   (input valid, r_x, r_y, r_z, r_w, path_taken, output ready);
endinterface

// ===== sv/qs_stage.sv =====
// One register stage of the slerp pipeline with its valid bit.
// Depends on qs_pkg (t_item, qs_step).
module qs_stage #(
    parameter int K     = 0,
    parameter int STEPS = qs_pkg::CORDIC_STEPS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qs_pkg::t_item i_item,
    input  logic [14:0]   i_thr,
    output logic          o_valid,
    output qs_pkg::t_item o_item
);
    logic          r_valid;
    qs_pkg::t_item r_item;
    qs_pkg::t_item n_item;

    always_comb begin
        n_item = qs_pkg::qs_step(K, STEPS, i_item, i_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== sv/quaternion_slerp.sv =====
// Top level of the quaternion slerp block: channels, threshold register, stage chain.
// Depends on qs_pkg, qs_if (qs_in_if, qs_out_if) and qs_stage.
//
//   channel   dir   handshake     item
//   i_in      in    valid/ready   a_x..a_w, b_x..b_w, blend
//   o_out     out   valid/ready   r_x..r_w, path_taken
//   apb       in    psel/penable  small_sine_threshold at byte address 0
//
// One item enters per cycle while o_out is not stalled; the stage chain holds the
// 31-step square root, the vectoring and rotation CORDIC chains and the
// 17-step divider.
// Each stage holds a valid bit and loads when it is empty or its successor loads,
// so a stall at o_out fills bubbles first and loses or repeats nothing.
// Synchronous active-low reset clears the valid bits and sets the threshold to 16.
module quaternion_slerp #(
    parameter int CORDIC_STEPS = qs_pkg::CORDIC_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qs_in_if.sink       i_in,
    qs_out_if.source    o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NST = qs_pkg::qs_stages(CORDIC_STEPS);

    logic [14:0]   r_thr;
    logic [NST:0]  w_en;
    logic [NST:0]  w_vld;
    qs_pkg::t_item w_item [NST+1];
    logic          w_sel;

    assign w_sel  = (paddr[2] == qs_pkg::ADDR_THR[2]);
    assign pready = 1'b1;
    assign prdata = w_sel ? {17'b0, r_thr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qs_pkg::THR_RESET;
        end else if (psel && penable && pwrite && w_sel) begin
            r_thr <= pwdata[14:0];
        end
    end

    always_comb begin
        w_item[0]      = '0;
        w_item[0].a[0] = i_in.a_x;
        w_item[0].a[1] = i_in.a_y;
        w_item[0].a[2] = i_in.a_z;
        w_item[0].a[3] = i_in.a_w;
        w_item[0].b[0] = i_in.b_x;
        w_item[0].b[1] = i_in.b_y;
        w_item[0].b[2] = i_in.b_z;
        w_item[0].b[3] = i_in.b_w;
        w_item[0].t    = i_in.blend;
    end

    assign w_vld[0]   = i_in.valid;
    assign w_en[NST]  = o_out.ready;
    assign i_in.ready = w_en[0];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        assign w_en[k] = !w_vld[k+1] || w_en[k+1];

        qs_stage #(
            .K     (k),
            .STEPS (CORDIC_STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[k]),
            .i_valid (w_vld[k]),
            .i_item  (w_item[k]),
            .i_thr   (r_thr),
            .o_valid (w_vld[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    assign o_out.valid      = w_vld[NST];
    assign o_out.r_x        = w_item[NST].r[0];
    assign o_out.r_y        = w_item[NST].r[1];
    assign o_out.r_z        = w_item[NST].r[2];
    assign o_out.r_w        = w_item[NST].r[3];
    assign o_out.path_taken = w_item[NST].path;
endmodule

// ===== sv/qs_checker.sv =====
// Port-level checks on the quaternion slerp block, bound to its top level.
// Depends on qs_pkg (ADDR_THR) and quaternion_slerp.
module qs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [65:0] i_out_data,
    input logic        i_psel,
    input logic        i_penable,
    input logic        i_pwrite,
    input logic [2:0]  i_paddr,
    input logic [31:0] i_pwdata,
    input logic [31:0] i_prdata
);
    // empty output stage means every stage can load
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output side is free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result item changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result item valid right after reset");

    a_thr_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_psel && i_penable && i_pwrite)
         && $past(i_paddr[2]) == qs_pkg::ADDR_THR[2]
         && i_paddr[2] == qs_pkg::ADDR_THR[2])
        |-> i_prdata == {17'b0, $past(i_pwdata[14:0])})
        else $error("threshold readback mismatch");

    a_no_accept_in_reset: assert property (@(posedge i_clk)
        (!$past(i_rst_n) && $past(i_in_valid)) |-> !i_out_valid)
        else $error("item leaked through reset");
endmodule

bind quaternion_slerp qs_checker u_qs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.r_x, o_out.r_y, o_out.r_z, o_out.r_w, o_out.path_taken}),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);

// ===== tb/qs_tb_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the quaternion slerp block: watches both channels, predicts
// each result from the accepted pair and the threshold, and counts mismatches.
// Depends on qs_pkg.
module qs_tb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_a [4],
    input  logic [15:0] i_b [4],
    input  logic [16:0] i_blend,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_r [4],
    input  logic [1:0]  i_path,
    input  logic [14:0] i_thr,
    output int          o_errors,
    output int          o_pending
);
    localparam longint PI_Q30   = 64'd3373259426;
    localparam longint HPI_Q30  = 64'd1686629713;
    localparam longint GAIN_Q30 = 64'd652032874;

    typedef struct {
        logic [15:0]   r [4];
        qs_pkg::t_path path;
    } t_slerp_res;

    t_slerp_res res_q[$];
    int         errors = 0;

    assign o_errors  = errors;
    assign o_pending = res_q.size();

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_at(int i);
        longint tab [16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
            262144, 131072, 65536, 32768};
        return tab[i];
    endfunction

    function automatic longint half_angle(longint x, longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < qs_pkg::CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_at(i);
            end else begin
                x -= dx; y += dy; z -= atan_at(i);
            end
        end
        return z;
    endfunction

    function automatic longint sine_q30(longint ang);
        longint x, y, z, dx, dy;
        x = GAIN_Q30;
        y = 0;
        if (ang > HPI_Q30) ang = PI_Q30 - ang;
        z = ang;
        for (int i = 0; i < qs_pkg::CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_at(i);
            end else begin
                x += dx; y -= dy; z += atan_at(i);
            end
        end
        return y;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned rem, root, b;
        rem = v; root = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic t_slerp_res slerp(logic [15:0] a [4], logic [15:0] b [4],
                                         logic [16:0] blend, logic [14:0] thr);
        t_slerp_res      o;
        longint          av [4], bv [4], c, theta, sa, sb, num, q;
        longint unsigned t, cmag, cq, s, mag;
        c = 0;
        for (int k = 0; k < 4; k++) begin
            av[k] = longint'($signed(a[k]));
            bv[k] = longint'($signed(b[k]));
            c += av[k] * bv[k];
        end
        t = (blend > 17'd65536) ? 65536 : blend;
        cmag = (c < 0) ? -c : c;
        if (cmag >= (64'd1 << 28)) begin
            for (int k = 0; k < 4; k++) o.r[k] = a[k];
            o.path = qs_pkg::PATH_A;
            return o;
        end
        cq = cmag << 2;
        s = root_floor((64'd1 << 60) - cq * cq);
        if (s < (longint'(thr) << 16)) begin
            for (int k = 0; k < 4; k++) o.r[k] = 16'(floor_shr(av[k] + bv[k], 1));
            o.path = qs_pkg::PATH_MID;
            return o;
        end
        theta = half_angle(cq, s);
        if (c < 0) theta = PI_Q30 - theta;
        if (theta < 0) theta = 0;
        sa = sine_q30((theta * longint'(65536 - t)) >>> 16);
        sb = sine_q30((theta * longint'(t)) >>> 16);
        for (int k = 0; k < 4; k++) begin
            num = av[k] * sa + bv[k] * sb;
            mag = (num < 0) ? -num : num;
            q = (mag + (s >> 1)) / s;
            if (num < 0) q = -q;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            o.r[k] = 16'(q);
        end
        o.path = qs_pkg::PATH_INTERP;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_slerp_res want;
        if (i_rst_n && i_in_valid && i_in_ready)
            res_q.push_back(slerp(i_a, i_b, i_blend, i_thr));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (res_q.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = res_q.pop_front();
                for (int k = 0; k < 4; k++)
                    if (i_r[k] !== want.r[k])
                        report_mismatch($sformatf("r[%0d]", k),
                                        $signed(i_r[k]), $signed(want.r[k]));
                if (i_path !== want.path)
                    report_mismatch("path", i_path, want.path);
            end
        end
    end
endmodule

// ===== tb/tb_quaternion_slerp.sv =====
`timescale 1ns / 1ps
// Testbench top for quaternion_slerp: clock, reset, APB threshold writes and
// randomized pair/result traffic. Depends on qs_pkg, qs_if, quaternion_slerp and qs_tb_checker.
module tb_quaternion_slerp;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic [14:0] thr_shadow = qs_pkg::THR_RESET;
    logic        rx_hold = 1'b0;
    logic        rx_random = 1'b1;
    int          errors, pending;
    logic [15:0] in_a [4], in_b [4], out_r [4];

    qs_in_if  in_ch ();
    qs_out_if out_ch ();

    always #2 i_clk = ~i_clk;

    quaternion_slerp u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    assign in_a  = '{in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.a_w};
    assign in_b  = '{in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.b_w};
    assign out_r = '{out_ch.r_x, out_ch.r_y, out_ch.r_z, out_ch.r_w};

    qs_tb_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
        .i_a(in_a), .i_b(in_b), .i_blend(in_ch.blend),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_r(out_r), .i_path(out_ch.path_taken), .i_thr(thr_shadow),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stalls or always ready, plus a long forced hold
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) out_ch.ready <= 1'b0;
            else if (!rx_random) out_ch.ready <= 1'b1;
            else if ($urandom_range(0, 9) < 7) out_ch.ready <= 1'b1;
            else out_ch.ready <= ($urandom_range(0, 19) == 0) ? 1'b1 : 1'b0;
        end
    end

    initial begin
        #200000000;
        $display("tb_quaternion_slerp failed");
        $finish;
    end

    task automatic write_thr(logic [14:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= qs_pkg::ADDR_THR; pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        thr_shadow <= v;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_pair(logic [15:0] q [8], logic [16:0] t);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ?
              (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.a_x <= q[0]; in_ch.a_y <= q[1]; in_ch.a_z <= q[2]; in_ch.a_w <= q[3];
        in_ch.b_x <= q[4]; in_ch.b_y <= q[5]; in_ch.b_z <= q[6]; in_ch.b_w <= q[7];
        in_ch.blend <= t;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
    endtask

    // random unit-ish quaternion, length near 1.0 (16384) or random bits
    function automatic void rand_pair(output logic [15:0] q [8]);
        int mode, n;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 8; k++) q[k] = 16'($urandom);
        if (mode < 7) begin
            n = $urandom_range(0, 3);
            for (int k = 0; k < 8; k++)
                q[k] = 16'($signed(16'($urandom_range(0, 16383) - 8192)));
            q[n] = 16'(($urandom_range(0, 1) ? -1 : 1) * $urandom_range(12000, 16384));
            q[n + 4] = 16'(($urandom_range(0, 1) ? -1 : 1) * $urandom_range(12000, 16384));
            if (mode == 6) for (int k = 0; k < 4; k++) q[k + 4] = q[k] + 16'($urandom_range(0, 6) - 3);
        end
    endfunction

    function automatic logic [16:0] rand_blend();
        int m;
        m = $urandom_range(0, 19);
        if (m == 0) return 17'd0;
        if (m == 1) return 17'd65536;
        if (m == 2) return 17'($urandom);
        return 17'($urandom_range(0, 65536));
    endfunction

    initial begin
        logic [15:0] q [8];
        logic [14:0] thr_set [4];
        thr_set = '{15'd0, 15'd16384, 15'd2000, 15'd16};
        in_ch.valid <= 1'b0;
        in_ch.a_x <= '0; in_ch.a_y <= '0; in_ch.a_z <= '0; in_ch.a_w <= '0;
        in_ch.b_x <= '0; in_ch.b_y <= '0; in_ch.b_z <= '0; in_ch.b_w <= '0;
        in_ch.blend <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, equal and opposite pairs, PATH_A and PATH_INTERP cases
        q = '{16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0};           send_pair(q, 17'd32768);
        q = '{16'h4000, 0, 0, 0, 16'hc000, 0, 0, 0};           send_pair(q, 17'd32768);
        q = '{16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0};           send_pair(q, 17'd0);
        q = '{16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0};           send_pair(q, 17'd65536);
        q = '{16'h4000, 0, 0, 0, 0, 16'h4000, 0, 0};           send_pair(q, 17'h1ffff);
        q = '{16'h4000, 0, 0, 0, 0, 16'hc000, 0, 0};           send_pair(q, 17'd16384);
        q = '{16'h3fff, 16'h0040, 0, 0, 16'h3fff, 16'hffc0, 0, 0}; send_pair(q, 17'd20000);
        q = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h8000, 16'h8000, 16'h8000, 16'h8000};          send_pair(q, 17'd1);
        q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 16'h8000, 16'h8000};          send_pair(q, 17'd65535);
        q = '{16'h8000, 16'h7fff, 0, 0, 16'hffff, 0, 16'h0001, 0}; send_pair(q, 17'd40000);
        q = '{16'h2d41, 16'h2d41, 0, 0, 16'h2d41, 16'hd2bf, 0, 0}; send_pair(q, 17'd32768);
        q = '{0, 0, 0, 0, 0, 0, 0, 0};                          send_pair(q, 17'd32768);
        q = '{16'h7fff, 0, 0, 0, 0, 16'h7fff, 0, 0};            send_pair(q, 17'd32768);
        q = '{16'h7fff, 0, 0, 0, 16'h0001, 16'h7fff, 0, 0};     send_pair(q, 17'd50000);
        stop_sending();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_thr(thr_set[ph]);
            @(posedge i_clk);
            if (ph == 1) begin
                // receiver held off while the sender keeps offering
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (400) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            rx_random <= (ph != 2);
            for (int n = 0; n < 125; n++) begin
                rand_pair(q);
                send_pair(q, rand_blend());
            end
            stop_sending();
            drain();
        end

        if (errors == 0) begin
            $display("tb_quaternion_slerp passed");
        end else begin
            $display("tb_quaternion_slerp failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/qs_pkg.sv
sv/qs_if.sv
sv/qs_stage.sv
sv/quaternion_slerp.sv
sv/qs_checker.sv
tb/qs_tb_checker.sv
tb/tb_quaternion_slerp.sv
